FILE: src/slpq_pkg.sv
// Package with the sizes, status codes and mode codes of the sorted-list priority queue.
`timescale 1ns / 1ps
package slpq_pkg;
    localparam int Capacity   = 16;
    localparam int ValueWidth = 16;
    localparam int IdxW       = $clog2(Capacity);
    localparam int CntW       = $clog2(Capacity + 1);

    typedef logic [ValueWidth-1:0] value_t;
    typedef logic [CntW-1:0]       count_t;
    typedef logic [IdxW-1:0]       index_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_EMPTY      = 2'd2;
    localparam logic       MODE_INSERT       = 1'b0;
    localparam logic       MODE_REMOVE       = 1'b1;
endpackage

FILE: src/sorted_list_priority_queue.sv
// Min-priority queue held as an ascending sorted list in a synchronous memory.
`timescale 1ns / 1ps
// Usage: pulse start with mode and value while busy is low. Mode 0 inserts
// value, mode 1 removes the smallest entry. For every accepted word exactly one
// result word appears for one cycle with done high: min_value, is_empty,
// is_full, entry_count and status. The receiver cannot stall the block.
// An insert walks the list from the tail, one memory read-modify-write per
// entry: each step reads entry k-1 and writes it to entry k, or the new value
// into its place. A removal walks from the head, moving entry k down to k-1.
// Each step uses the single read port and then the single write port of the
// list memory, so the next entry is not read before the last one is written.
// The next word can be taken in the cycle after the result cycle.
// After the move the head entry is read back to report the minimum. Refused
// words (insert when full, remove when empty) skip the move and go straight
// to the head read. Reset clears the count; the memory contents are not
// cleared. Entries beyond the count are never reported: entry 0 is read even
// when the list is empty, but min_value is then forced to zero.
module sorted_list_priority_queue
    import slpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [15:0] value,
    output logic        done,
    output logic [15:0] min_value,
    output logic        is_empty,
    output logic        is_full,
    output logic [4:0]  entry_count,
    output logic [1:0]  status
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MOVE  = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_HWAIT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    value_t mem [Capacity];
    value_t rd_data_reg;
    logic   rd_en, wr_en;
    index_t rd_addr, wr_addr;
    value_t wr_data;

    logic [2:0] state_reg, state_next;
    count_t     cnt_reg, cnt_next;
    count_t     k_reg, k_next;
    logic       mode_reg, mode_next;
    value_t     val_reg, val_next;
    logic [1:0] stat_reg, stat_next;
    logic       done_reg, done_next;

    // Synchronous memory with one read and one write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        mode_reg <= mode_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
    end

    // Sequencer: walks the list one entry per read/write pair.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        mode_next  = mode_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = '0;
        wr_addr    = '0;
        wr_data    = val_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    val_next  = value[ValueWidth-1:0];
                    stat_next = STATUS_OK;
                    if (mode == MODE_INSERT)
                    begin
                        if (cnt_reg == count_t'(Capacity))
                        begin
                            stat_next  = STATUS_FULL;
                            state_next = ST_HEAD;
                        end
                        else
                        begin
                            k_next     = cnt_reg;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            stat_next  = STATUS_EMPTY;
                            state_next = ST_HEAD;
                        end
                        else
                        begin
                            k_next     = count_t'(1);
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    if (k_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = index_t'(0);
                        cnt_next   = cnt_reg + count_t'(1);
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = index_t'(k_reg - count_t'(1));
                        state_next = ST_MOVE;
                    end
                end
                else
                begin
                    if (k_reg == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - count_t'(1);
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = index_t'(k_reg);
                        state_next = ST_MOVE;
                    end
                end
            end
            ST_MOVE:
            begin
                wr_en = 1'b1;
                if (mode_reg == MODE_INSERT)
                begin
                    // Entry k-1 is not smaller than the new value: shift it up.
                    if (rd_data_reg >= val_reg)
                    begin
                        wr_addr    = index_t'(k_reg);
                        wr_data    = rd_data_reg;
                        k_next     = k_reg - count_t'(1);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        wr_addr    = index_t'(k_reg);
                        wr_data    = val_reg;
                        cnt_next   = cnt_reg + count_t'(1);
                        state_next = ST_HEAD;
                    end
                end
                else
                begin
                    wr_addr    = index_t'(k_reg - count_t'(1));
                    wr_data    = rd_data_reg;
                    k_next     = k_reg + count_t'(1);
                    state_next = ST_READ;
                end
            end
            ST_HEAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = index_t'(0);
                state_next = ST_HWAIT;
            end
            ST_HWAIT:
            begin
                done_next  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word is presented during the ST_DONE cycle.
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign min_value   = (cnt_reg == '0) ? 16'd0 : 16'(rd_data_reg);
    assign is_empty    = (cnt_reg == '0);
    assign is_full     = (cnt_reg == count_t'(Capacity));
    assign entry_count = 5'(cnt_reg);
    assign status      = stat_reg;
endmodule

FILE: test/tb_sorted_list_priority_queue.sv
// Testbench for the sorted-list priority queue: random and directed words, scoreboard check.
`timescale 1ns / 1ps
module tb_sorted_list_priority_queue;
    import slpq_pkg::*;

    // Scoreboard that mirrors the sorted list and holds the expected result words.
    class queue_scoreboard;
        logic [15:0] mirror_list[$];
        logic [15:0] exp_min[$];
        logic        exp_empty[$];
        logic        exp_full[$];
        logic [4:0]  exp_count[$];
        logic [1:0]  exp_status[$];
        int          error_count;

        // Apply one accepted word to the mirror and queue the expected result.
        function void note_word(logic m, logic [15:0] v);
            logic [1:0] st;
            int pos;
            st = STATUS_OK;
            if (m == MODE_INSERT)
            begin
                if (mirror_list.size() >= Capacity)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < mirror_list.size() && mirror_list[pos] < v)
                        pos++;
                    mirror_list.insert(pos, v);
                end
            end
            else
            begin
                if (mirror_list.size() == 0)
                    st = STATUS_EMPTY;
                else
                    void'(mirror_list.pop_front());
            end
            exp_min.push_back(mirror_list.size() > 0 ? mirror_list[0] : 16'd0);
            exp_empty.push_back(mirror_list.size() == 0);
            exp_full.push_back(mirror_list.size() == Capacity);
            exp_count.push_back(5'(mirror_list.size()));
            exp_status.push_back(st);
        endfunction

        // Compare one result word against the oldest expectation.
        function void check_result(logic [15:0] mv, logic e, logic f, logic [4:0] c,
                                   logic [1:0] s);
            if (exp_min.size() == 0)
            begin
                $error("result word with no expectation waiting");
                error_count++;
                return;
            end
            if (mv !== exp_min[0])
            begin
                $error("min_value expected %0d actual %0d", exp_min[0], mv);
                error_count++;
            end
            if (e !== exp_empty[0])
            begin
                $error("is_empty expected %0d actual %0d", exp_empty[0], e);
                error_count++;
            end
            if (f !== exp_full[0])
            begin
                $error("is_full expected %0d actual %0d", exp_full[0], f);
                error_count++;
            end
            if (c !== exp_count[0])
            begin
                $error("entry_count expected %0d actual %0d", exp_count[0], c);
                error_count++;
            end
            if (s !== exp_status[0])
            begin
                $error("status expected %0d actual %0d", exp_status[0], s);
                error_count++;
            end
            void'(exp_min.pop_front());
            void'(exp_empty.pop_front());
            void'(exp_full.pop_front());
            void'(exp_count.pop_front());
            void'(exp_status.pop_front());
        endfunction

        function int pending();
            return exp_min.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [15:0] value;
    logic        done;
    logic [15:0] min_value;
    logic        is_empty;
    logic        is_full;
    logic [4:0]  entry_count;
    logic [1:0]  status;

    queue_scoreboard board;
    bit quiet_stretch;

    sorted_list_priority_queue u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .value(value), .done(done), .min_value(min_value), .is_empty(is_empty),
        .is_full(is_full), .entry_count(entry_count), .status(status)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: worst case about 2000 words; reports an error and ends the run if reached.
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Check every result word at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(min_value, is_empty, is_full, entry_count, status);
    end

    // Send one word: optional random gap with start low, then hold start until
    // accepted. Start stays high afterwards; busy keeps the block from taking it
    // again until the next word is driven.
    task automatic send_word(logic m, logic [15:0] v);
        while (!quiet_stretch && $urandom_range(99) < 28)
        begin
            start <= 1'b0;
            mode  <= 1'($urandom_range(1));
            value <= 16'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        mode  <= m;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        board.note_word(m, v);
    endtask

    // Random value with a bias toward extremes and small values, for ties.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(7));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int fill_bias;
        int wait_cycles;
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        mode  = 1'b0;
        value = 16'd0;
        quiet_stretch = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: removal when empty, extremes, ties, fill past full, drain past empty.
        send_word(MODE_REMOVE, 16'd0);
        send_word(MODE_INSERT, 16'hFFFF);
        send_word(MODE_INSERT, 16'h0000);
        send_word(MODE_INSERT, 16'h0000);
        send_word(MODE_INSERT, 16'h5555);
        send_word(MODE_INSERT, 16'hAAAA);
        for (int i = 0; i < 12; i++)
            send_word(MODE_INSERT, 16'(16'h8000 >> i));
        send_word(MODE_INSERT, 16'h1234);
        for (int i = 0; i < 17; i++)
            send_word(MODE_REMOVE, 16'hFFFF);

        // Random: swing between filling and draining so both ends are reached.
        for (int i = 0; i < 1950; i++)
        begin
            quiet_stretch = (i >= 600 && i < 800);
            if (i % 100 == 0)
                fill_bias = $urandom_range(20, 80);
            if ($urandom_range(99) < fill_bias)
                send_word(MODE_INSERT, pick_value());
            else
                send_word(MODE_REMOVE, 16'($urandom));
        end
        start <= 1'b0;

        // Wait for the outstanding result words, then a short settle.
        wait_cycles = 0;
        while (board.pending() > 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (board.error_count == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: files.f
src/slpq_pkg.sv
src/sorted_list_priority_queue.sv
test/tb_sorted_list_priority_queue.sv
